// ===== rtl/tadc_pkg.sv =====
// ----------------------------------------------------------------------------
// tadc_pkg
// Shared constants, types and resistance table for the thermistor
// ADC-to-temperature converter.
// ----------------------------------------------------------------------------
package tadc_pkg;

  // Table and converter sizing
  localparam int TABLE_ENTRIES = 11;
  localparam int ADC_BITS      = 10;
  localparam int SEG_W         = $clog2(TABLE_ENTRIES);
  localparam logic [ADC_BITS-1:0] ADC_FULL = {ADC_BITS{1'b1}};

  // Datapath widths
  localparam int TBL_W   = 19;                 // table entries, tenths of an ohm
  localparam int D_W     = ADC_BITS;           // FULL - count
  localparam int P_W     = TBL_W + D_W;        // table * d
  localparam int C10_W   = ADC_BITS + 4;       // 10 * count
  localparam int SER_W   = 20;
  localparam int STEP_W  = 14;
  localparam int S_W     = SER_W + C10_W;      // 10 * series * count
  localparam int MAG_W   = S_W;                // |table*d - s|
  localparam int NUM_W   = MAG_W + STEP_W;     // step * |table*d - s|
  localparam int DEN_W   = P_W;                // d * segment span
  localparam int DVD_W   = NUM_W + 1;          // numerator plus half divisor
  localparam int BASE_W  = SEG_W + STEP_W;     // seg * step
  localparam int T_W     = DVD_W + 2;          // signed temperature sum
  localparam int TEMP_W  = 18;
  localparam int ST_W    = 2;
  localparam int CNT_W   = $clog2(DVD_W);

  localparam int TEMP_LIMIT = 100000;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SER_W;
  localparam logic [CFG_IDX_W-1:0] REG_SERIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd1;
  localparam logic [SER_W-1:0]  SERIES_RESET = 20'd10000;
  localparam logic [STEP_W-1:0] STEP_RESET   = 14'd500;

  // Result status codes
  localparam logic [ST_W-1:0] ST_IN   = 2'd0;
  localparam logic [ST_W-1:0] ST_COLD = 2'd1;
  localparam logic [ST_W-1:0] ST_HOT  = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD  = 2'd3;

  // Falling resistances, 0 C to 50 C in 5 C steps, tenths of an ohm
  localparam logic [TBL_W-1:0] RES_TABLE [TABLE_ENTRIES] = '{
    19'd326240, 19'd253810, 19'd198970, 19'd157110, 19'd124930, 19'd100000,
    19'd80560,  19'd65297,  19'd53239,  19'd43653,  19'd35987
  };

  // Controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             smul;
    logic             scan;
    logic [SEG_W-1:0] idx;
    logic             hd;
    logic             den;
    logic             num;
    logic             prep;
    logic             div_step;
    logic             out_load;
  } tadc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic bad;
    logic out_busy;
  } tadc_stat_t;

  function automatic logic [TBL_W-1:0] tbl_val(input logic [SEG_W-1:0] k);
    logic [TBL_W-1:0] v;
    v = '0;
    if (int'(k) < TABLE_ENTRIES) v = RES_TABLE[k];
    return v;
  endfunction

  // Resistance drop across segment k
  function automatic logic [TBL_W-1:0] tbl_span(input logic [SEG_W-1:0] k);
    return tbl_val(k) - tbl_val(k + SEG_W'(1));
  endfunction

endpackage

// ===== rtl/tadc_if.sv =====
// ----------------------------------------------------------------------------
// tadc_if
// Valid/ready channel interfaces: ADC request, temperature result and
// configuration write.
// ----------------------------------------------------------------------------
interface tadc_in_if import tadc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_counts;

  modport source (output valid, output adc_counts, input ready);
  modport sink   (input valid, input adc_counts, output ready);
endinterface

interface tadc_out_if import tadc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_centi_c;
  logic [ST_W-1:0]          status;

  modport source (output valid, output temperature_centi_c, output status, input ready);
  modport sink   (input valid, input temperature_centi_c, input status, output ready);
endinterface

interface tadc_cfg_if import tadc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tadc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tadc_ctrl
// Sequencer for one conversion: resistance product, table scan, segment
// setup, serial division and result write.
// ----------------------------------------------------------------------------
module tadc_ctrl import tadc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  tadc_stat_t stat,
  output tadc_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SMUL = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_HD   = 4'd3;
  localparam logic [3:0] S_DEN  = 4'd4;
  localparam logic [3:0] S_NUM  = 4'd5;
  localparam logic [3:0] S_PREP = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DVD_W - 1);

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and step counter
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) state_nxt = S_SMUL;
      end
      S_SMUL: state_nxt = stat.bad ? S_FIN : S_SCAN;
      S_SCAN: begin
        if (cnt_r == SCAN_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_HD;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_HD:   state_nxt = S_DEN;
      S_DEN:  state_nxt = S_NUM;
      S_NUM:  state_nxt = S_PREP;
      S_PREP: state_nxt = S_DIV;
      S_DIV: begin
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_FIN:  if (!stat.out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == S_IDLE) && in_valid;
    cmd.smul     = (state_r == S_SMUL);
    cmd.scan     = (state_r == S_SCAN);
    cmd.idx      = cnt_r[SEG_W-1:0];
    cmd.hd       = (state_r == S_HD);
    cmd.den      = (state_r == S_DEN);
    cmd.num      = (state_r == S_NUM);
    cmd.prep     = (state_r == S_PREP);
    cmd.div_step = (state_r == S_DIV);
    cmd.out_load = (state_r == S_FIN) && !stat.out_busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Scan index never runs past the table
  a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> cnt_r <= SCAN_LAST)
    else $error("table scan index out of range");

  // A result is written only into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !stat.out_busy)
    else $error("result written over a pending one");

endmodule

// ===== rtl/tadc_dp.sv =====
// ----------------------------------------------------------------------------
// tadc_dp
// Datapath: configuration registers, shared table multiplier, scan compare,
// restoring divider and saturating output register.
// ----------------------------------------------------------------------------
module tadc_dp import tadc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [ADC_BITS-1:0] in_adc,
  tadc_cfg_if.sink            cfg_ch,
  tadc_out_if.source          out_ch,
  input  tadc_cmd_t           cmd,
  output tadc_stat_t          stat
);

  logic [SER_W-1:0]  series_r;
  logic [STEP_W-1:0] step_r;

  logic [D_W-1:0]    d_r;
  logic [C10_W-1:0]  c10_r;
  logic              bad_r;
  logic [S_W-1:0]    s_r;
  logic              cold_r, hot_r, found_r;
  logic [SEG_W-1:0]  seg_r;
  logic              neg_r;
  logic [MAG_W-1:0]  mag_r;
  logic [DEN_W-1:0]  den_r;
  logic [BASE_W-1:0] base_r;
  logic [NUM_W-1:0]  num_r;
  logic [DVD_W-1:0]  q_r;
  logic [DEN_W-1:0]  rem_r;

  logic                     out_valid_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic [ST_W-1:0]          status_r;

  logic [TBL_W-1:0]  mul_a;
  logic [P_W-1:0]    mul_p;
  logic              gt, lt;
  logic [DEN_W:0]    trial;
  logic              trial_ge;
  logic signed [T_W-1:0] t_sum, t_sat;
  logic [ST_W-1:0]   st_nxt;

  // Configuration writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      series_r <= SERIES_RESET;
      step_r   <= STEP_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_SERIES: series_r <= cfg_ch.data;
        REG_STEP:   step_r   <= cfg_ch.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared table-times-d multiplier
  always_comb begin
    mul_a = tbl_span(seg_r);
    if (cmd.scan)    mul_a = tbl_val(cmd.idx);
    else if (cmd.hd) mul_a = tbl_val(seg_r);
  end

  assign mul_p = P_W'(mul_a) * P_W'(d_r);
  assign gt    = s_r > S_W'(mul_p);
  assign lt    = s_r < S_W'(mul_p);

  // Divider trial subtract
  assign trial    = {rem_r, q_r[DVD_W-1]};
  assign trial_ge = trial >= {1'b0, den_r};

  // Final sum and saturation
  always_comb begin
    if (neg_r) t_sum = T_W'(base_r) - T_W'(q_r);
    else       t_sum = T_W'(base_r) + T_W'(q_r);
    t_sat = t_sum;
    if (t_sum > T_W'(TEMP_LIMIT))  t_sat = T_W'(TEMP_LIMIT);
    if (t_sum < -T_W'(TEMP_LIMIT)) t_sat = -T_W'(TEMP_LIMIT);
    st_nxt = ST_IN;
    if (bad_r)       st_nxt = ST_BAD;
    else if (cold_r) st_nxt = ST_COLD;
    else if (hot_r)  st_nxt = ST_HOT;
  end

  // Conversion datapath
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d_r   <= ADC_FULL - in_adc;
      c10_r <= (C10_W'(in_adc) << 3) + (C10_W'(in_adc) << 1);
      bad_r <= (in_adc == '0) || (in_adc == ADC_FULL);
    end
    if (cmd.smul) s_r <= S_W'(series_r) * S_W'(c10_r);
    // Segment search: first entry below R picks the segment before it
    if (cmd.scan) begin
      if (cmd.idx == '0) begin
        cold_r  <= gt;
        found_r <= 1'b0;
        seg_r   <= SEG_W'(TABLE_ENTRIES - 2);
      end else if (gt && !found_r) begin
        found_r <= 1'b1;
        seg_r   <= cmd.idx - SEG_W'(1);
      end
      if (cmd.idx == SEG_W'(TABLE_ENTRIES - 1)) hot_r <= lt;
    end
    if (cmd.hd) begin
      neg_r <= lt == 1'b0 && gt;
      mag_r <= gt ? s_r - S_W'(mul_p) : S_W'(mul_p) - s_r;
    end
    if (cmd.den) begin
      den_r  <= mul_p;
      base_r <= BASE_W'(seg_r) * BASE_W'(step_r);
    end
    if (cmd.num) num_r <= NUM_W'(mag_r) * NUM_W'(step_r);
    // Round to nearest: add half the divisor before dividing
    if (cmd.prep) begin
      q_r   <= DVD_W'(num_r) + DVD_W'(den_r >> 1);
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      q_r   <= {q_r[DVD_W-2:0], trial_ge};
      rem_r <= trial_ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    end
    if (cmd.out_load) begin
      temp_r   <= bad_r ? '0 : t_sat[TEMP_W-1:0];
      status_r <= st_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n)              out_valid_r <= 1'b0;
    else if (cmd.out_load)   out_valid_r <= 1'b1;
    else if (out_ch.ready)   out_valid_r <= 1'b0;
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.temperature_centi_c = temp_r;
  assign out_ch.status              = status_r;

  assign stat.bad      = bad_r;
  assign stat.out_busy = out_valid_r && !out_ch.ready;

  // Remainder stays below the divisor through the division
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |=> rem_r < den_r)
    else $error("divider remainder not reduced");

  // Invalid counts report zero temperature
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_BAD) |-> temp_r == '0)
    else $error("invalid count with nonzero temperature");

  // Result stays within the saturation limits
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (temp_r <= TEMP_W'(TEMP_LIMIT)) && (temp_r >= -TEMP_W'(TEMP_LIMIT)))
    else $error("temperature outside saturation limits");

endmodule

// ===== rtl/thermistor_adc_to_temperature.sv =====
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature
// Converts a thermistor divider ADC count to temperature in 0.01 C.
// ----------------------------------------------------------------------------
// A request goes from acceptance to the result register through one step for
// 10*series*count, a scan of the resistance table through one shared
// table-times-d multiplier, four setup steps, the bit-serial restoring
// divider and the result write; a count of 0 or full scale goes from the
// product straight to the write. If the previous result is still unread
// at that point, the write waits until it is read.
// A new request is taken as soon as the result is in the output register,
// even while it waits to be read. Status 0 is
// inside the table, 1 colder (first segment extended), 2 hotter (last
// segment extended), 3 an invalid count with temperature 0. Write the
// series resistor (index 0) and segment span (index 1) only while idle.
module thermistor_adc_to_temperature import tadc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  tadc_in_if.sink     in_ch,
  tadc_out_if.source  out_ch,
  tadc_cfg_if.sink    cfg_ch
);

  tadc_cmd_t  cmd;
  tadc_stat_t stat;
  logic       in_ready;

  assign in_ch.ready = in_ready;

  tadc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tadc_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_adc (in_ch.adc_counts),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule

// ===== sim/tb_thermistor_adc_to_temperature.sv =====
// ----------------------------------------------------------------------------
// tb_thermistor_adc_to_temperature
// Self-checking bench for the thermistor count-to-temperature converter.
// A local predictor works out resistance, table segment, interpolation,
// rounding and saturation from the register values and each request. It
// checks every result in order. Directed cases cover the count extremes,
// both table ends, the zero and full-scale registers, saturation and unused
// register indexes. Random traffic then runs under several register values
// and handshake idling patterns.
// ----------------------------------------------------------------------------
module tb_thermistor_adc_to_temperature;
  import tadc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT      = 1000000;
  localparam int END_WAIT_CYCLES  = 80;       // a little over one conversion's latency
  localparam int RANDOM_SETTINGS  = 5;        // register settings per idling phase
  localparam int ITEMS_PER_SETTING = 95;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  localparam logic [SER_W-1:0]  SERIES_DEFAULT = 20'd10000;
  localparam logic [STEP_W-1:0] STEP_DEFAULT   = 14'd500;
  localparam logic [SER_W-1:0]  SERIES_MAX     = {SER_W{1'b1}};
  localparam logic [STEP_W-1:0] STEP_MAX       = {STEP_W{1'b1}};

  // Thermistor resistance at 0..50 C, tenths of an ohm (independent copy)
  localparam longint DIVIDER_RES_TENTHS [TABLE_ENTRIES] = '{
    326240, 253810, 198970, 157110, 124930, 100000,
    80560,  65297,  53239,  43653,  35987
  };

  typedef struct packed {
    logic [ADC_BITS-1:0]      counts;
    logic signed [TEMP_W-1:0] temp_centi;
    logic [ST_W-1:0]          status;
  } reading_t;

  logic clk;
  logic rst_n;

  tadc_in_if  in_bus ();
  tadc_out_if out_bus ();
  tadc_cfg_if cfg_bus ();

  thermistor_adc_to_temperature u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // Register mirror and pending results
  logic [SER_W-1:0]  series_ohms_now = SERIES_DEFAULT;
  logic [STEP_W-1:0] step_centi_now  = STEP_DEFAULT;
  reading_t          expected_readings[$];

  int mismatch_count     = 0;
  int cycle_count        = 0;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;

  // Clock, 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Expected temperature and status for one count under the current registers
  function automatic reading_t predict_reading(input logic [ADC_BITS-1:0] counts);
    reading_t r;
    longint   d, s, stp, hi, lo, num, den, mag, q, t;
    int       seg, i;
    bit       found;
    r.counts     = counts;
    r.temp_centi = '0;
    r.status     = ST_IN;
    if (counts == '0 || counts == ADC_FULL) begin
      r.status = ST_BAD;
      return r;
    end
    d   = longint'(ADC_FULL) - longint'(counts);
    s   = 10 * longint'(series_ohms_now) * longint'(counts);
    stp = longint'(step_centi_now);
    // first breakpoint below R picks the segment; none means the last one
    seg   = TABLE_ENTRIES - 2;
    found = 1'b0;
    for (i = 1; i < TABLE_ENTRIES; i++) begin
      if (!found && s > DIVIDER_RES_TENTHS[i] * d) begin
        seg   = i - 1;
        found = 1'b1;
      end
    end
    if (s > DIVIDER_RES_TENTHS[0] * d) begin
      r.status = ST_COLD;
    end else if (s < DIVIDER_RES_TENTHS[TABLE_ENTRIES-1] * d) begin
      r.status = ST_HOT;
    end
    hi  = DIVIDER_RES_TENTHS[seg];
    lo  = DIVIDER_RES_TENTHS[seg+1];
    num = stp * (hi * d - s);
    den = d * (hi - lo);
    // round half away from zero
    mag = (num < 0) ? -num : num;
    q   = (mag + den / 2) / den;
    if (num < 0) q = -q;
    t = longint'(seg) * stp + q;
    if (t > TEMP_LIMIT) t = TEMP_LIMIT;
    if (t < -TEMP_LIMIT) t = -TEMP_LIMIT;
    r.temp_centi = t[TEMP_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Result checker, sampled at the rising edge
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch($sformatf("result with no request pending: temp=%0d status=%0d",
                                  out_bus.temperature_centi_c, out_bus.status));
      end else begin
        want = expected_readings.pop_front();
        if (out_bus.temperature_centi_c !== want.temp_centi)
          report_mismatch($sformatf("count %0d: temp %0d, expected %0d",
                                    want.counts, out_bus.temperature_centi_c,
                                    want.temp_centi));
        if (out_bus.status !== want.status)
          report_mismatch($sformatf("count %0d: status %0d, expected %0d",
                                    want.counts, out_bus.status, want.status));
      end
    end
  end

  // Result-side backpressure
  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL thermistor_adc_to_temperature");
    $finish;
  end

  // Send one request; called and returns at a falling edge, valid left high
  task automatic send_counts(input logic [ADC_BITS-1:0] counts);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid      = 1'b1;
    in_bus.adc_counts = counts;
    do @(posedge clk); while (!in_bus.ready);
    expected_readings.push_back(predict_reading(counts));
    @(negedge clk);
  endtask

  // Stop sending and wait until every result has been read
  task automatic drain;
    in_bus.valid = 1'b0;
    while (expected_readings.size() != 0) @(negedge clk);
  endtask

  // One register write; leaves cfg valid high for a following write
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = value;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx == REG_SERIES) begin
      series_ohms_now = value[SER_W-1:0];
    end else if (idx == REG_STEP) begin
      step_centi_now = value[STEP_W-1:0];
    end
    @(negedge clk);
  endtask

  // Both registers, written only with the converter idle
  task automatic set_config(input logic [CFG_DATA_W-1:0] series,
                            input logic [CFG_DATA_W-1:0] step);
    drain;
    write_register(REG_SERIES, series);
    write_register(REG_STEP, step);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  // Count extremes and alternating bit patterns with reset registers
  task automatic test_reset_defaults;
    send_counts(10'd0);
    send_counts(ADC_FULL);
    send_counts(10'd1);
    send_counts(10'd1022);
    send_counts(10'd512);
    send_counts(10'd511);
    send_counts(10'h155);
    send_counts(10'h2AA);
  endtask

  // R lands exactly on the first and the last breakpoint
  task automatic test_table_ends;
    set_config(20'd65248, STEP_DEFAULT);   // 341 counts -> 32624.0 ohm
    send_counts(10'd341);
    set_config(20'd35987, STEP_DEFAULT);   // 93 counts -> 3598.7 ohm
    send_counts(10'd93);
  endtask

  // Writes to indexes past the register list must not disturb anything
  task automatic test_unused_indexes;
    drain;
    write_register(REG_UNUSED_2, SERIES_MAX);
    write_register(REG_UNUSED_3, '0);
    cfg_bus.valid = 1'b0;
    send_counts(10'd583);
    send_counts(10'd300);
  endtask

  // Extrapolation far past both ends clips to the temperature limits
  task automatic test_saturation;
    set_config(SERIES_MAX, STEP_MAX);
    send_counts(10'd1022);
    send_counts(10'd1);
    send_counts(10'd700);
    set_config(20'd1, STEP_MAX);
    send_counts(10'd1);
    send_counts(10'd1022);
  endtask

  // Zero series resistor reads as hot; zero span gives zero temperature
  task automatic test_zero_registers;
    set_config('0, STEP_DEFAULT);
    send_counts(10'd1);
    send_counts(10'd512);
    send_counts(10'd1022);
    set_config(SERIES_DEFAULT, '0);
    send_counts(10'd200);
    send_counts(10'd600);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_series;
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(7))
      0:       v = SERIES_DEFAULT;
      1:       v = '0;
      2:       v = 20'd1;
      3:       v = SERIES_MAX;
      4:       v = CFG_DATA_W'($urandom_range(1000, 50000));
      5, 6:    v = CFG_DATA_W'($urandom_range(1, 1000000));
      default: v = CFG_DATA_W'($urandom);
    endcase
    return v;
  endfunction

  // Span values; upper data bits are random since the register ignores them
  function automatic logic [CFG_DATA_W-1:0] pick_step;
    logic [STEP_W-1:0] v;
    case ($urandom_range(7))
      0:       v = STEP_DEFAULT;
      1:       v = '0;
      2:       v = STEP_MAX;
      3:       v = 14'd10000;
      4, 5:    v = STEP_W'($urandom_range(1, 10000));
      default: v = STEP_W'($urandom);
    endcase
    return {(CFG_DATA_W - STEP_W)'($urandom), v};
  endfunction

  function automatic logic [ADC_BITS-1:0] pick_counts;
    logic [ADC_BITS-1:0] v;
    if ($urandom_range(99) < 6) begin
      case ($urandom_range(3))
        0:       v = '0;
        1:       v = 10'd1;
        2:       v = 10'd1022;
        default: v = ADC_FULL;
      endcase
    end else begin
      v = ADC_BITS'($urandom_range(0, 1023));
    end
    return v;
  endfunction

  // Random counts under several register settings, one idling pattern
  task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
    int k, n;
    set_idling(sender_pct, receiver_pct);
    for (k = 0; k < RANDOM_SETTINGS; k++) begin
      if (k == 0) begin
        set_config(SERIES_DEFAULT, STEP_DEFAULT);
      end else begin
        set_config(pick_series(), pick_step());
      end
      for (n = 0; n < ITEMS_PER_SETTING; n++) send_counts(pick_counts());
    end
  endtask

  // Main sequence
  initial begin
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.adc_counts  = '0;
    out_bus.ready      = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = REG_SERIES;
    cfg_bus.data       = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_idling(0, 0);
    test_reset_defaults;
    test_table_ends;
    test_unused_indexes;
    test_saturation;
    test_zero_registers;

    test_random_traffic(0, 0);
    test_random_traffic(72, 0);
    test_random_traffic(0, 72);
    test_random_traffic(10, 10);

    drain;
    repeat (END_WAIT_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS thermistor_adc_to_temperature");
    end else begin
      $display("FAIL thermistor_adc_to_temperature");
    end
    $finish;
  end

endmodule
